@@ sv/sfd_pkg.sv @@
// Shared types, codes and constants for the sensor frame decoder.
// No dependencies; every other file imports this package.
package sfd_pkg;

    localparam int FRAME_BYTES = 11;
    localparam int IDX_W       = $clog2(FRAME_BYTES + 1);

    // item commands
    localparam logic [1:0] CMD_DATA  = 2'd0;
    localparam logic [1:0] CMD_EVAL  = 2'd1;
    localparam logic [1:0] CMD_RSTEP = 2'd2;

    // result status codes
    localparam logic [2:0] ST_BAD_HDR = 3'd0;
    localparam logic [2:0] ST_BAD_SUM = 3'd1;
    localparam logic [2:0] ST_CAL_ACK = 3'd2;
    localparam logic [2:0] ST_STORED  = 3'd3;
    localparam logic [2:0] ST_IGNORED = 3'd4;

    // frame contents
    localparam logic [7:0] HEADER_BYTE = 8'h55;
    localparam logic [7:0] OP_CAL      = 8'h83;
    localparam logic [7:0] OP_READING  = 8'h85;
    localparam logic [7:0] CHAN_ONE    = 8'h01;
    localparam logic [7:0] CHAN_TWO    = 8'h02;

    // x/20 = ((x >> 2) * RECIP_5) >> RECIP_SHIFT, exact for 16-bit x
    localparam logic [15:0] RECIP_5     = 16'hCCCD;
    localparam int          RECIP_SHIFT = 18;

    localparam logic [1:0] STEP_LAST = 2'd2;

    typedef logic [FRAME_BYTES-1:0][7:0] frame_t;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [11:0] tds_ch1;
        logic [11:0] tds_ch2;
        logic [15:0] temp_ch1;
        logic [15:0] temp_ch2;
        logic [1:0]  cal_step;
    } out_item_t;

    // decision for one frame-end item
    typedef struct packed {
        logic [2:0]  status;
        logic        frame_ok;
        logic        cal_adv;
        logic        store_one;
        logic        store_two;
        logic [11:0] tds;
        logic [15:0] temp;
    } eval_t;

endpackage

@@ sv/sensor_frame_decoder.sv @@
// Sensor frame decoder top level: input register, frame store, evaluation,
// reading and calibration registers, result register. Depends on sfd_pkg.
// Timing: an item is taken into the input register and processed from there;
// a frame-end result is registered as the item retires, which a held result can stall.
// Throughput: one item per cycle; only a frame-end item waits on a held result.
// Reset (rst_n, async, active low) clears the store, index, step and readings.
module sensor_frame_decoder
    import sfd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    output logic      item_stall,
    input  in_item_t  item,
    output logic      result_valid,
    input  logic      result_stall,
    output out_item_t result
);

    // input register
    logic      in_valid_reg;
    logic      in_valid_next;
    in_item_t  in_item_reg;

    // stored readings and calibration step
    logic [1:0]  step_reg;
    logic [1:0]  step_next;
    logic [11:0] tds_one_reg;
    logic [11:0] tds_one_next;
    logic [11:0] tds_two_reg;
    logic [11:0] tds_two_next;
    logic [15:0] temp_one_reg;
    logic [15:0] temp_one_next;
    logic [15:0] temp_two_reg;
    logic [15:0] temp_two_next;

    // result register
    logic      out_valid_reg;
    logic      out_valid_next;
    out_item_t out_item_reg;
    out_item_t out_item_next;

    logic   is_eval;
    logic   advance;
    frame_t frame;
    eval_t  dec;

    assign is_eval = (in_item_reg.command == CMD_EVAL);

    // A frame-end item may only retire when the result register is free
    // or being emptied this cycle; every other item retires at once.
    assign advance    = in_valid_reg && (!is_eval || !out_valid_reg || !result_stall);
    assign item_stall = in_valid_reg && !advance;

    sfd_frame_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .byte_wr (advance && (in_item_reg.command == CMD_DATA)),
        .wr_byte (in_item_reg.rx_byte),
        .restart (advance && is_eval),
        .clear   (advance && is_eval && dec.frame_ok),
        .frame   (frame)
    );

    sfd_eval u_eval (
        .frame (frame),
        .dec   (dec)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (item_valid && !item_stall)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    // update stored state for the item in the input register
    always_comb
    begin
        step_next     = step_reg;
        tds_one_next  = tds_one_reg;
        tds_two_next  = tds_two_reg;
        temp_one_next = temp_one_reg;
        temp_two_next = temp_two_reg;
        if (advance)
        begin
            case (in_item_reg.command)
                CMD_RSTEP:
                begin
                    step_next = '0;
                end
                CMD_EVAL:
                begin
                    // advance the step, hold at the last one
                    if (dec.cal_adv && (step_reg != STEP_LAST))
                    begin
                        step_next = step_reg + 2'd1;
                    end
                    if (dec.store_one)
                    begin
                        tds_one_next  = dec.tds;
                        temp_one_next = dec.temp;
                    end
                    if (dec.store_two)
                    begin
                        tds_two_next  = dec.tds;
                        temp_two_next = dec.temp;
                    end
                end
                default:
                begin
                    // data bytes go to the store; unused code is dropped
                end
            endcase
        end
    end

    always_comb
    begin
        out_item_next          = out_item_reg;
        out_valid_next         = out_valid_reg;
        if (advance && is_eval)
        begin
            out_valid_next         = 1'b1;
            out_item_next.status   = dec.status;
            out_item_next.tds_ch1  = tds_one_next;
            out_item_next.tds_ch2  = tds_two_next;
            out_item_next.temp_ch1 = temp_one_next;
            out_item_next.temp_ch2 = temp_two_next;
            out_item_next.cal_step = step_next;
        end
        else if (!result_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
            tds_one_reg   <= '0;
            tds_two_reg   <= '0;
            temp_one_reg  <= '0;
            temp_two_reg  <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            step_reg      <= step_next;
            tds_one_reg   <= tds_one_next;
            tds_two_reg   <= tds_two_next;
            temp_one_reg  <= temp_one_next;
            temp_two_reg  <= temp_two_next;
        end
    end

    // payload registers: hold unless loaded
    always_ff @(posedge clk)
    begin
        if (item_valid && !item_stall)
        begin
            in_item_reg <= item;
        end
        out_item_reg <= out_item_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_item_reg;

    // never retire a frame-end item over a held result
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && result_stall) |-> !(advance && is_eval))
        else $error("frame-end item retired over a held result");

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg != 2'd3)
        else $error("calibration step out of range");

    a_step_reset: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (in_item_reg.command == CMD_RSTEP)) |=> (step_reg == 2'd0))
        else $error("reset-step item did not clear the step");

    a_result_tds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((out_item_reg.tds_ch1 == tds_one_reg)
                        && (out_item_reg.tds_ch2 == tds_two_reg)))
        else $error("pending result disagrees with stored readings");

endmodule

@@ sv/sfd_frame_store.sv @@
// Frame byte store with its write index, clear on a valid frame.
// Depends on sfd_pkg.
module sfd_frame_store
    import sfd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_wr,
    input  logic [7:0] wr_byte,
    input  logic       restart,
    input  logic       clear,
    output frame_t     frame
);

    frame_t           store_reg;
    frame_t           store_next;
    logic [IDX_W-1:0] index_reg;
    logic [IDX_W-1:0] index_next;

    always_comb
    begin
        store_next = store_reg;
        index_next = index_reg;
        if (clear)
        begin
            store_next = '0;
        end
        if (restart)
        begin
            index_next = '0;
        end
        else if (byte_wr && (index_reg < IDX_W'(FRAME_BYTES)))
        begin
            // drop bytes once the store is full
            for (int i = 0; i < FRAME_BYTES; i++)
            begin
                if (index_reg == IDX_W'(i))
                begin
                    store_next[i] = wr_byte;
                end
            end
            index_next = index_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            store_reg <= '0;
            index_reg <= '0;
        end
        else
        begin
            store_reg <= store_next;
            index_reg <= index_next;
        end
    end

    assign frame = store_reg;

endmodule

@@ sv/sfd_eval.sv @@
// Frame check and action decode: header, checksum, command, TDS divide.
// Depends on sfd_pkg.
module sfd_eval
    import sfd_pkg::*;
(
    input  frame_t frame,
    output eval_t  dec
);

    logic [7:0]  sum;
    logic [15:0] tds_word;
    logic [13:0] quarter;
    logic [29:0] product;

    assign sum = ((frame[0] + frame[1]) + (frame[2] + frame[3]))
               + ((frame[4] + frame[5]) + (frame[6] + frame[7]))
               + (frame[8] + frame[9]);

    assign tds_word = {frame[4], frame[5]};
    assign quarter  = tds_word[15:2];
    assign product  = quarter * RECIP_5;

    always_comb
    begin
        dec           = '0;
        dec.tds       = product[RECIP_SHIFT +: 12];
        dec.temp      = {frame[6], frame[7]};
        dec.status    = ST_IGNORED;
        if (frame[0] != HEADER_BYTE)
        begin
            dec.status = ST_BAD_HDR;
        end
        else if (frame[10] != sum)
        begin
            dec.status = ST_BAD_SUM;
        end
        else
        begin
            dec.frame_ok = 1'b1;
            if (frame[2] == OP_CAL)
            begin
                dec.cal_adv = 1'b1;
                dec.status  = ST_CAL_ACK;
            end
            else if (frame[2] == OP_READING)
            begin
                if (frame[3] == CHAN_ONE)
                begin
                    dec.store_one = 1'b1;
                    dec.status    = ST_STORED;
                end
                else if (frame[3] == CHAN_TWO)
                begin
                    dec.store_two = 1'b1;
                    dec.status    = ST_STORED;
                end
            end
        end
    end

endmodule

@@ sim/tb_sensor_frame_decoder.sv @@
// Self-checking testbench for sensor_frame_decoder: a directed table, then random
// frames, checked against a behavioral predictor of the decoder or typed-in rows.
// Depends on sfd_pkg and the sensor_frame_decoder RTL.
module tb_sensor_frame_decoder;

    import sfd_pkg::*;

    // command code 3 carries no meaning; the decoder must ignore it
    localparam logic [1:0] CMD_NONE = 2'd3;

    localparam int TDS_DIVISOR    = 20;
    localparam int RANDOM_ITEMS   = 500;
    localparam int DIR_ROWS       = 21;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 10;
    localparam int REPORT_LIMIT   = 10;

    logic      clk;
    logic      rst_n;
    logic      item_valid;
    logic      item_stall;
    in_item_t  item;
    logic      result_valid;
    logic      result_stall;
    out_item_t result;

    sensor_frame_decoder u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // Predictor state: frame bytes, fill position, calibration step, readings.
    logic [7:0]  frame_copy [FRAME_BYTES] = '{default: 8'h00};
    int          fill_count    = 0;
    logic [1:0]  step_copy     = '0;
    logic [11:0] tds_one_copy  = '0;
    logic [11:0] tds_two_copy  = '0;
    logic [15:0] temp_one_copy = '0;
    logic [15:0] temp_two_copy = '0;

    out_item_t pending_results [$];
    out_item_t want;
    int        mismatches  = 0;
    int        items_sent  = 0;
    int        idle_cycles = 0;
    bit        src_burst   = 1'b0;
    bit        snk_burst   = 1'b0;

    // Directed rows: stimulus item, and a typed-in expectation where one is
    // obvious. Readings stay zero throughout, so only status and step are given.
    typedef struct packed {
        in_item_t   stim;
        bit         typed;
        logic [2:0] want_status;
        logic [1:0] want_step;
    } dir_row_t;

    dir_row_t directed_rows [DIR_ROWS] = '{
        // empty store straight out of reset: header check fails
        '{'{CMD_EVAL,  8'h00}, 1'b1, ST_BAD_HDR, 2'd0},
        // header alone: sum of 0x55 against a zero check byte
        '{'{CMD_DATA,  8'h55}, 1'b0, ST_BAD_HDR, 2'd0},
        '{'{CMD_EVAL,  8'hFF}, 1'b1, ST_BAD_SUM, 2'd0},
        '{'{CMD_RSTEP, 8'h00}, 1'b0, ST_BAD_HDR, 2'd0},
        // calibration frame, overwriting the kept invalid frame from byte 0
        '{'{CMD_DATA,  8'h55}, 1'b0, ST_BAD_HDR, 2'd0},
        '{'{CMD_DATA,  8'h00}, 1'b0, ST_BAD_HDR, 2'd0},
        '{'{CMD_DATA,  OP_CAL}, 1'b0, ST_BAD_HDR, 2'd0},
        '{'{CMD_DATA,  8'h00}, 1'b0, ST_BAD_HDR, 2'd0},
        '{'{CMD_DATA,  8'h00}, 1'b0, ST_BAD_HDR, 2'd0},
        '{'{CMD_DATA,  8'h00}, 1'b0, ST_BAD_HDR, 2'd0},
        '{'{CMD_DATA,  8'h00}, 1'b0, ST_BAD_HDR, 2'd0},
        '{'{CMD_DATA,  8'h00}, 1'b0, ST_BAD_HDR, 2'd0},
        '{'{CMD_DATA,  8'h00}, 1'b0, ST_BAD_HDR, 2'd0},
        '{'{CMD_DATA,  8'hFF}, 1'b0, ST_BAD_HDR, 2'd0},
        '{'{CMD_DATA,  8'hD7}, 1'b0, ST_BAD_HDR, 2'd0},
        // twelfth byte lands on a full store and must be dropped
        '{'{CMD_DATA,  8'hFF}, 1'b0, ST_BAD_HDR, 2'd0},
        '{'{CMD_NONE,  8'hFF}, 1'b0, ST_BAD_HDR, 2'd0},
        '{'{CMD_EVAL,  8'h00}, 1'b1, ST_CAL_ACK, 2'd1},
        // valid frame cleared the store, so the header is gone again
        '{'{CMD_EVAL,  8'h00}, 1'b1, ST_BAD_HDR, 2'd1},
        '{'{CMD_RSTEP, 8'hAA}, 1'b0, ST_BAD_HDR, 2'd0},
        '{'{CMD_EVAL,  8'h00}, 1'b1, ST_BAD_HDR, 2'd0}
    };

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Apply one accepted item to the predictor; return 1 when it yields a result.
    function automatic bit predict_item(input in_item_t it, output out_item_t res);
        logic [7:0]  sum;
        logic [15:0] word;
        logic [2:0]  st;
        res = '0;
        if (it.command == CMD_DATA)
        begin
            if (fill_count < FRAME_BYTES)
            begin
                frame_copy[fill_count] = it.rx_byte;
                fill_count++;
            end
            return 1'b0;
        end
        if (it.command == CMD_RSTEP)
        begin
            step_copy = '0;
            return 1'b0;
        end
        if (it.command != CMD_EVAL)
            return 1'b0;

        fill_count = 0;
        sum = '0;
        for (int i = 0; i < FRAME_BYTES - 1; i++)
            sum += frame_copy[i];
        if (frame_copy[0] != HEADER_BYTE)
            st = ST_BAD_HDR;
        else if (frame_copy[FRAME_BYTES-1] != sum)
            st = ST_BAD_SUM;
        else
        begin
            st = ST_IGNORED;
            if (frame_copy[2] == OP_CAL)
            begin
                if (step_copy != STEP_LAST)
                    step_copy++;
                st = ST_CAL_ACK;
            end
            else if (frame_copy[2] == OP_READING)
            begin
                word = {frame_copy[4], frame_copy[5]};
                if (frame_copy[3] == CHAN_ONE)
                begin
                    tds_one_copy  = 12'(word / TDS_DIVISOR);
                    temp_one_copy = {frame_copy[6], frame_copy[7]};
                    st = ST_STORED;
                end
                else if (frame_copy[3] == CHAN_TWO)
                begin
                    tds_two_copy  = 12'(word / TDS_DIVISOR);
                    temp_two_copy = {frame_copy[6], frame_copy[7]};
                    st = ST_STORED;
                end
            end
            foreach (frame_copy[i])
                frame_copy[i] = 8'h00;
        end
        res.status   = st;
        res.tds_ch1  = tds_one_copy;
        res.tds_ch2  = tds_two_copy;
        res.temp_ch1 = temp_one_copy;
        res.temp_ch2 = temp_two_copy;
        res.cal_step = step_copy;
        return 1'b1;
    endfunction

    // Offer one item after a random gap, hold it until taken, then predict.
    // Enter and leave at a falling edge.
    task automatic send_item(input in_item_t it, input bit use_typed,
                             input out_item_t typed_res);
        int        gap;
        out_item_t pred;
        if ($urandom_range(0, 31) == 0)
            src_burst = !src_burst;
        gap = src_burst ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item       <= it;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (item_stall !== 1'b0);
        if (predict_item(it, pred))
            pending_results.push_back(use_typed ? typed_res : pred);
        if (it.command != CMD_NONE)
            items_sent++;
        @(negedge clk);
    endtask

    // Drop valid and hold off until every predicted result has come back.
    task automatic hold_until_drained();
        item_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending_results.size() != 0);
    endtask

    // Build one mostly well-formed frame with random content, then evaluate it.
    // A fraction gets a bad header, a bad check byte, a short or long length,
    // or a stray item in the middle.
    task automatic send_random_frame();
        logic [7:0] fb [FRAME_BYTES];
        logic [7:0] sum;
        int         len;
        int         pick;
        in_item_t   it;
        fb[0] = ($urandom_range(0, 9) == 0) ? 8'($urandom) : HEADER_BYTE;
        fb[1] = 8'($urandom);
        pick  = $urandom_range(0, 9);
        fb[2] = (pick < 4) ? OP_CAL : (pick < 8) ? OP_READING : 8'($urandom);
        pick  = $urandom_range(0, 9);
        fb[3] = (pick < 4) ? CHAN_ONE : (pick < 8) ? CHAN_TWO : 8'($urandom);
        // lean the reading words toward their extremes
        for (int i = 4; i < FRAME_BYTES - 1; i++)
        begin
            pick  = $urandom_range(0, 3);
            fb[i] = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom);
        end
        sum = '0;
        for (int i = 0; i < FRAME_BYTES - 1; i++)
            sum += fb[i];
        fb[FRAME_BYTES-1] = ($urandom_range(0, 6) == 0) ?
                            sum ^ 8'($urandom_range(1, 255)) : sum;

        pick = $urandom_range(0, 9);
        if (pick == 0)
            len = $urandom_range(0, FRAME_BYTES - 1);
        else if (pick == 1)
            len = $urandom_range(FRAME_BYTES + 1, FRAME_BYTES + 3);
        else
            len = FRAME_BYTES;

        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 39) == 0)
            begin
                it.command = 2'($urandom_range(0, 3));
                it.rx_byte = 8'($urandom);
                send_item(it, 1'b0, '0);
            end
            it.command = CMD_DATA;
            it.rx_byte = (i < FRAME_BYTES) ? fb[i] : 8'($urandom);
            send_item(it, 1'b0, '0);
        end
        if ($urandom_range(0, 7) == 0)
        begin
            it.command = CMD_RSTEP;
            it.rx_byte = 8'($urandom);
            send_item(it, 1'b0, '0);
        end
        if ($urandom_range(0, 15) == 0)
        begin
            it.command = CMD_NONE;
            it.rx_byte = 8'($urandom);
            send_item(it, 1'b0, '0);
        end
        it.command = CMD_EVAL;
        it.rx_byte = 8'($urandom);
        send_item(it, 1'b0, '0);
    endtask

    // Result side: stall either ahead of a result or once it shows up.
    initial
    begin
        int stall_len;
        result_stall = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if ($urandom_range(0, 15) == 0)
                snk_burst = !snk_burst;
            stall_len = snk_burst ? 0 : $urandom_range(0, 15);
            if (stall_len > 0 && $urandom_range(0, 3) == 0)
            begin
                result_stall <= 1'b1;
                repeat (stall_len) @(negedge clk);
                result_stall <= 1'b0;
            end
            else
            begin
                while (result_valid !== 1'b1)
                    @(negedge clk);
                if (stall_len > 0)
                begin
                    result_stall <= 1'b1;
                    repeat (stall_len) @(negedge clk);
                end
                result_stall <= 1'b0;
            end
            do
                @(posedge clk);
            while (!(result_valid === 1'b1 && result_stall === 1'b0));
            @(negedge clk);
        end
    end

    // Compare every accepted result against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && result_valid === 1'b1 && result_stall === 1'b0)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected result: status %0d step %0d",
                             result.status, result.cal_step);
            end
            else
            begin
                want = pending_results.pop_front();
                if (result.status   !== want.status   ||
                    result.tds_ch1  !== want.tds_ch1  ||
                    result.tds_ch2  !== want.tds_ch2  ||
                    result.temp_ch1 !== want.temp_ch1 ||
                    result.temp_ch2 !== want.temp_ch2 ||
                    result.cal_step !== want.cal_step)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                    begin
                        $display("mismatch: exp st %0d tds %0d/%0d temp %h/%h step %0d",
                                 want.status, want.tds_ch1, want.tds_ch2,
                                 want.temp_ch1, want.temp_ch2, want.cal_step);
                        $display("          got st %0d tds %0d/%0d temp %h/%h step %0d",
                                 result.status, result.tds_ch1, result.tds_ch2,
                                 result.temp_ch1, result.temp_ch2, result.cal_step);
                    end
                end
            end
        end
    end

    // Watchdog: end the run if neither side moves an item for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_valid === 1'b1 && item_stall === 1'b0) ||
                (result_valid === 1'b1 && result_stall === 1'b0))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        out_item_t typed_res;
        rst_n      = 1'b0;
        item_valid = 1'b0;
        item       = '0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Walk the directed table; typed rows override the predicted result.
        foreach (directed_rows[r])
        begin
            typed_res          = '0;
            typed_res.status   = directed_rows[r].want_status;
            typed_res.cal_step = directed_rows[r].want_step;
            send_item(directed_rows[r].stim, directed_rows[r].typed, typed_res);
        end
        hold_until_drained();

        while (items_sent < DIR_ROWS + RANDOM_ITEMS)
        begin
            send_random_frame();
            if ($urandom_range(0, 9) == 0)
                hold_until_drained();
        end

        hold_until_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);
        mismatches += pending_results.size();
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
sv/sfd_pkg.sv
sv/sfd_frame_store.sv
sv/sfd_eval.sv
sv/sensor_frame_decoder.sv
sim/tb_sensor_frame_decoder.sv
